// ===== hdl/rfcdma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcdma_pkg
// shared types and constants for the rectangle fill/copy dma engine
// ----------------------------------------------------------------------------
package rfcdma_pkg;

    localparam int ADDR_W   = 32;
    localparam int PIXEL_W  = 32;
    localparam int SKIP_W   = 14;
    localparam int COL_W    = 14;
    localparam int LINE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // bytes per pixel
    localparam logic [ADDR_W-1:0] PIXEL_BYTES = 32'd4;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_STEP  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRANSFER_MODE  = 3'd0,
        REG_OUT_BASE       = 3'd1,
        REG_OUT_SKIP       = 3'd2,
        REG_SOURCE_BASE    = 3'd3,
        REG_SOURCE_SKIP    = 3'd4,
        REG_PIXELS_PER_LINE = 3'd5,
        REG_LINE_COUNT     = 3'd6,
        REG_FILL_COLOR     = 3'd7
    } cfg_index_t;

    typedef enum logic {
        MODE_FILL = 1'b0,
        MODE_COPY = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t               transfer_mode;
        logic [ADDR_W-1:0]   out_base_address;
        logic [SKIP_W-1:0]   out_line_skip;
        logic [ADDR_W-1:0]   source_base_address;
        logic [SKIP_W-1:0]   source_line_skip;
        logic [COL_W-1:0]    pixels_per_line;
        logic [LINE_W-1:0]   line_count;
        logic [PIXEL_W-1:0]  fill_color;
    } cfg_t;

    typedef struct packed {
        logic                write_valid;
        logic [ADDR_W-1:0]   write_address;
        logic [PIXEL_W-1:0]  write_data;
        logic [ADDR_W-1:0]   next_read_address;
        logic                busy;
        logic                complete;
        logic                last_pixel;
    } result_t;

endpackage

// ===== hdl/rfcdma_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcdma_cfg_regs
// configuration register file, written by index, read live by the engine
// ----------------------------------------------------------------------------
module rfcdma_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rfcdma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfcdma_pkg::CFG_DATA_W-1:0] cfg_data,
    output rfcdma_pkg::cfg_t                  cfg
);
    import rfcdma_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_TRANSFER_MODE:   cfg_next.transfer_mode       = mode_t'(cfg_data[0]);
                REG_OUT_BASE:        cfg_next.out_base_address    = cfg_data;
                REG_OUT_SKIP:        cfg_next.out_line_skip       = cfg_data[SKIP_W-1:0];
                REG_SOURCE_BASE:     cfg_next.source_base_address = cfg_data;
                REG_SOURCE_SKIP:     cfg_next.source_line_skip    = cfg_data[SKIP_W-1:0];
                REG_PIXELS_PER_LINE: cfg_next.pixels_per_line     = cfg_data[COL_W-1:0];
                REG_LINE_COUNT:      cfg_next.line_count          = cfg_data[LINE_W-1:0];
                REG_FILL_COLOR:      cfg_next.fill_color          = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/rfcdma_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcdma_engine
// address and counter state with the single-pass update for one transaction
// ----------------------------------------------------------------------------
module rfcdma_engine
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  rfcdma_pkg::kind_t               kind,
    input  logic [rfcdma_pkg::PIXEL_W-1:0]  source_pixel,
    input  rfcdma_pkg::cfg_t                cfg,
    output rfcdma_pkg::result_t             res
);
    import rfcdma_pkg::*;

    logic [ADDR_W-1:0] out_address_reg,    out_address_next;
    logic [ADDR_W-1:0] source_address_reg, source_address_next;
    logic [COL_W-1:0]  column_counter_reg, column_counter_next;
    logic [LINE_W-1:0] line_counter_reg,   line_counter_next;
    logic              busy_reg,           busy_next;
    logic              complete_reg,       complete_next;

    logic [COL_W:0]    column_plus;
    logic [LINE_W:0]   line_plus;
    logic              line_end;
    logic              rect_end;
    logic [ADDR_W-1:0] out_step;
    logic [ADDR_W-1:0] source_step;
    logic [ADDR_W-1:0] out_skip_bytes;
    logic [ADDR_W-1:0] source_skip_bytes;
    logic              empty_rect;

    assign column_plus = {1'b0, column_counter_reg} + {{COL_W{1'b0}}, 1'b1};
    assign line_plus   = {1'b0, line_counter_reg} + {{LINE_W{1'b0}}, 1'b1};
    // compare as "reaches or passes" so a shrunk size still terminates
    assign line_end    = column_plus >= {1'b0, cfg.pixels_per_line};
    assign rect_end    = line_plus >= {1'b0, cfg.line_count};
    assign empty_rect  = (cfg.pixels_per_line == '0) || (cfg.line_count == '0);

    assign out_skip_bytes    = {{(ADDR_W-SKIP_W-2){1'b0}}, cfg.out_line_skip, 2'b00};
    assign source_skip_bytes = {{(ADDR_W-SKIP_W-2){1'b0}}, cfg.source_line_skip, 2'b00};
    assign out_step    = out_address_reg + PIXEL_BYTES;
    assign source_step = source_address_reg + PIXEL_BYTES;

    always_comb
    begin
        out_address_next    = out_address_reg;
        source_address_next = source_address_reg;
        column_counter_next = column_counter_reg;
        line_counter_next   = line_counter_reg;
        busy_next           = busy_reg;
        complete_next       = complete_reg;
        res.write_valid     = 1'b0;
        res.write_address   = '0;
        res.write_data      = '0;
        res.last_pixel      = 1'b0;

        unique case (kind)
            KIND_START:
            begin
                if (!busy_reg)
                begin
                    out_address_next    = cfg.out_base_address;
                    source_address_next = cfg.source_base_address;
                    column_counter_next = '0;
                    line_counter_next   = '0;
                    if (empty_rect)
                        complete_next = 1'b1;
                    else
                        busy_next = 1'b1;
                end
            end
            KIND_STEP:
            begin
                if (busy_reg)
                begin
                    res.write_valid   = 1'b1;
                    res.write_address = out_address_reg;
                    res.write_data    = (cfg.transfer_mode == MODE_COPY) ? source_pixel
                                                                         : cfg.fill_color;
                    if (line_end)
                    begin
                        column_counter_next = '0;
                        out_address_next    = out_step + out_skip_bytes;
                        source_address_next = source_step + source_skip_bytes;
                        if (rect_end)
                        begin
                            line_counter_next = '0;
                            busy_next         = 1'b0;
                            complete_next     = 1'b1;
                            res.last_pixel    = 1'b1;
                        end
                        else
                        begin
                            line_counter_next = line_plus[LINE_W-1:0];
                        end
                    end
                    else
                    begin
                        column_counter_next = column_plus[COL_W-1:0];
                        out_address_next    = out_step;
                        source_address_next = source_step;
                    end
                end
            end
            KIND_CLEAR:
            begin
                complete_next = 1'b0;
            end
            default:
            begin
                complete_next = complete_reg;
            end
        endcase

        res.next_read_address = source_address_next;
        res.busy              = busy_next;
        res.complete          = complete_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_address_reg    <= '0;
            source_address_reg <= '0;
            column_counter_reg <= '0;
            line_counter_reg   <= '0;
            busy_reg           <= 1'b0;
            complete_reg       <= 1'b0;
        end
        else if (fire)
        begin
            out_address_reg    <= out_address_next;
            source_address_reg <= source_address_next;
            column_counter_reg <= column_counter_next;
            line_counter_reg   <= line_counter_next;
            busy_reg           <= busy_next;
            complete_reg       <= complete_next;
        end
    end

    a_last_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.last_pixel |-> res.write_valid && !res.busy && res.complete)
        else $error("last pixel did not end the transfer");

    a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.write_valid |-> busy_reg)
        else $error("pixel write issued while idle");

    a_clear_drops_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && kind == KIND_CLEAR |=> !complete_reg)
        else $error("clear did not drop the complete flag");

    a_idle_counters_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> column_counter_reg == '0 && line_counter_reg == '0)
        else $error("counters not cleared while idle");

endmodule

// ===== hdl/rect_fill_copy_dma_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_copy_dma_engine
// two-dimensional fill/copy dma engine for 32-bit pixels
//
// usage: program the eight registers through cfg_we/cfg_index/cfg_data while
// the block is idle. each input transaction (kind, source_pixel) yields one
// result transaction: a start loads the address counters, a pixel step
// issues one pixel write and advances the addresses, a clear drops the
// sticky complete flag. next_read_address tells the host which source word
// to supply with the following step in copy mode.
// path: a transaction accepted lands in the input register, is processed
// into the result register once that register is free, and is taken from
// the output from there.
// throughput: one transaction per cycle while the receiver does not stall;
// the address adders and counters between the registers are combinational.
// reset clears the registers, the counters, busy and the complete flag.
// when the receiver stalls, the result register holds and the input
// register still takes one more transaction before in_ready drops.
// ----------------------------------------------------------------------------
module rect_fill_copy_dma_engine
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rfcdma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfcdma_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic [rfcdma_pkg::PIXEL_W-1:0]    source_pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              write_valid,
    output logic [rfcdma_pkg::ADDR_W-1:0]     write_address,
    output logic [rfcdma_pkg::PIXEL_W-1:0]    write_data,
    output logic [rfcdma_pkg::ADDR_W-1:0]     next_read_address,
    output logic                              busy_res,
    output logic                              complete_flag,
    output logic                              last_pixel
);
    import rfcdma_pkg::*;

    cfg_t                cfg;
    result_t             res;
    result_t             res_reg;
    logic                out_valid_reg, out_valid_next;
    logic                in_valid_reg,  in_valid_next;
    logic [1:0]          kind_reg;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic                advance;
    logic                fire;
    logic                in_take;

    rfcdma_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfcdma_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .kind         (kind_t'(kind_reg)),
        .source_pixel (pixel_reg),
        .cfg          (cfg),
        .res          (res)
    );

    // result register frees when empty or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        in_valid_next  = in_take || (in_valid_reg && !advance);
        out_valid_next = fire || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= kind;
            pixel_reg <= source_pixel;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign write_valid       = res_reg.write_valid;
    assign write_address     = res_reg.write_address;
    assign write_data        = res_reg.write_data;
    assign next_read_address = res_reg.next_read_address;
    assign busy_res          = res_reg.busy;
    assign complete_flag     = res_reg.complete;
    assign last_pixel        = res_reg.last_pixel;

endmodule

// ===== bench/rfcdma_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfcdma_checker
// watches the register port and both transaction channels of the dma
// engine, keeps its own copy of the registers and counters, predicts the
// result of every accepted input transaction and compares each returned
// result with the oldest prediction, field by field
// ----------------------------------------------------------------------------
module rfcdma_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rfcdma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rfcdma_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [1:0]                        kind,
    input  logic [rfcdma_pkg::PIXEL_W-1:0]    source_pixel,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              write_valid,
    input  logic [rfcdma_pkg::ADDR_W-1:0]     write_address,
    input  logic [rfcdma_pkg::PIXEL_W-1:0]    write_data,
    input  logic [rfcdma_pkg::ADDR_W-1:0]     next_read_address,
    input  logic                              busy_res,
    input  logic                              complete_flag,
    input  logic                              last_pixel,
    output int                                mismatches,
    output int                                outstanding,
    output int                                pixel_writes,
    output int                                rectangles_done
);

    import rfcdma_pkg::*;

    localparam int PRINT_LIMIT = 40;

    cfg_t              regs;
    logic [ADDR_W-1:0] out_addr;
    logic [ADDR_W-1:0] src_addr;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
    logic              busy;
    logic              complete;
    result_t           results_due[$];

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // one input transaction against the shadow state
    task automatic advance_dma(input logic [1:0] k, input logic [PIXEL_W-1:0] px,
                               output result_t r);
        r = '0;
        if (k == KIND_START) begin
            if (!busy) begin
                out_addr = regs.out_base_address;
                src_addr = regs.source_base_address;
                column   = '0;
                line     = '0;
                // empty rectangle finishes without ever going busy
                if (regs.pixels_per_line == '0 || regs.line_count == '0)
                    complete = 1'b1;
                else
                    busy = 1'b1;
            end
        end
        else if (k == KIND_STEP) begin
            if (busy) begin
                r.write_valid   = 1'b1;
                r.write_address = out_addr;
                r.write_data    = (regs.transfer_mode == MODE_COPY) ? px : regs.fill_color;
                out_addr = out_addr + PIXEL_BYTES;
                src_addr = src_addr + PIXEL_BYTES;
                // registers are live, so a counter may already be past its limit
                if ({18'd0, column} + 32'd1 >= {18'd0, regs.pixels_per_line}) begin
                    column   = '0;
                    out_addr = out_addr + {16'd0, regs.out_line_skip, 2'b00};
                    src_addr = src_addr + {16'd0, regs.source_line_skip, 2'b00};
                    if ({16'd0, line} + 32'd1 >= {16'd0, regs.line_count}) begin
                        line         = '0;
                        busy         = 1'b0;
                        complete     = 1'b1;
                        r.last_pixel = 1'b1;
                    end
                    else
                    begin
                        line = line + 1'b1;
                    end
                end
                else
                begin
                    column = column + 1'b1;
                end
            end
        end
        else if (k == KIND_CLEAR) begin
            complete = 1'b0;
        end
        r.next_read_address = src_addr;
        r.busy              = busy;
        r.complete          = complete;
    endtask

    always @(posedge clk)
    begin : watch
        result_t want;
        result_t fresh;
        if (!rst_n) begin
            regs            = '0;
            out_addr        = '0;
            src_addr        = '0;
            column          = '0;
            line            = '0;
            busy            = 1'b0;
            complete        = 1'b0;
            mismatches      = 0;
            pixel_writes    = 0;
            rectangles_done = 0;
            results_due.delete();
        end
        else
        begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TRANSFER_MODE:   regs.transfer_mode       = mode_t'(cfg_data[0]);
                    REG_OUT_BASE:        regs.out_base_address    = cfg_data;
                    REG_OUT_SKIP:        regs.out_line_skip       = cfg_data[SKIP_W-1:0];
                    REG_SOURCE_BASE:     regs.source_base_address = cfg_data;
                    REG_SOURCE_SKIP:     regs.source_line_skip    = cfg_data[SKIP_W-1:0];
                    REG_PIXELS_PER_LINE: regs.pixels_per_line     = cfg_data[COL_W-1:0];
                    REG_LINE_COUNT:      regs.line_count          = cfg_data[LINE_W-1:0];
                    REG_FILL_COLOR:      regs.fill_color          = cfg_data;
                    default: ;
                endcase
            end

            // compare before pushing: a result leaving now belongs to an older transaction
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf("result with none outstanding, address %h",
                                              write_address));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (write_valid !== want.write_valid)
                        report_mismatch($sformatf("write_valid %b, expected %b",
                                                  write_valid, want.write_valid));
                    if (write_address !== want.write_address)
                        report_mismatch($sformatf("write_address %h, expected %h",
                                                  write_address, want.write_address));
                    if (write_data !== want.write_data)
                        report_mismatch($sformatf("write_data %h, expected %h",
                                                  write_data, want.write_data));
                    if (next_read_address !== want.next_read_address)
                        report_mismatch($sformatf("next_read_address %h, expected %h",
                                                  next_read_address, want.next_read_address));
                    if (busy_res !== want.busy)
                        report_mismatch($sformatf("busy_res %b, expected %b",
                                                  busy_res, want.busy));
                    if (complete_flag !== want.complete)
                        report_mismatch($sformatf("complete_flag %b, expected %b",
                                                  complete_flag, want.complete));
                    if (last_pixel !== want.last_pixel)
                        report_mismatch($sformatf("last_pixel %b, expected %b",
                                                  last_pixel, want.last_pixel));
                end
            end

            if (in_valid && in_ready) begin
                advance_dma(kind, source_pixel, fresh);
                if (fresh.write_valid)
                    pixel_writes++;
                if (fresh.last_pixel)
                    rectangles_done++;
                results_due.push_back(fresh);
            end
        end
        outstanding = results_due.size();
    end

endmodule

// ===== bench/rect_fill_copy_dma_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_fill_copy_dma_engine_test
// drives fill and copy rectangles through the dma engine: a directed pass
// over empty rectangles, address wrap, maximum sizes and live register
// changes, then randomized setups with random gaps and output stalls. the
// checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module rect_fill_copy_dma_engine_test;

    import rfcdma_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [7:0] ALL_REGS    = 8'hFF;
    localparam logic [7:0] SIZE_REGS   = (8'd1 << REG_PIXELS_PER_LINE)
                                       | (8'd1 << REG_LINE_COUNT);

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [1:0]            kind         = KIND_STEP;
    logic [PIXEL_W-1:0]    source_pixel = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  write_valid;
    logic [ADDR_W-1:0]     write_address;
    logic [PIXEL_W-1:0]    write_data;
    logic [ADDR_W-1:0]     next_read_address;
    logic                  busy_res;
    logic                  complete_flag;
    logic                  last_pixel;

    int mismatches;
    int outstanding;
    int pixel_writes;
    int rectangles_done;
    int items_sent    = 0;
    int setups_loaded = 0;
    int idle_cycles   = 0;
    int stall_left    = 0;
    bit quiet         = 1'b0;

    rect_fill_copy_dma_engine uut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .source_pixel      (source_pixel),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .write_valid       (write_valid),
        .write_address     (write_address),
        .write_data        (write_data),
        .next_read_address (next_read_address),
        .busy_res          (busy_res),
        .complete_flag     (complete_flag),
        .last_pixel        (last_pixel)
    );

    rfcdma_checker dma_watch
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .source_pixel      (source_pixel),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .write_valid       (write_valid),
        .write_address     (write_address),
        .write_data        (write_data),
        .next_read_address (next_read_address),
        .busy_res          (busy_res),
        .complete_flag     (complete_flag),
        .last_pixel        (last_pixel),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .pixel_writes      (pixel_writes),
        .rectangles_done   (rectangles_done)
    );

    always #CLK_HALF clk = ~clk;

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom();
    endfunction

    // receiver side stalls
    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called and returns at a falling edge; valid stays high for a back-to-back transaction
    task automatic push_item(input logic [1:0] k, input logic [PIXEL_W-1:0] px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        source_pixel <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // drain the pipeline so registers can be written safely
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setup(input cfg_t s, input logic [7:0] mask);
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < 8; i++) begin
            if (mask[i]) begin
                case (cfg_index_t'(i))
                    REG_TRANSFER_MODE:   word = {31'd0, s.transfer_mode};
                    REG_OUT_BASE:        word = s.out_base_address;
                    REG_OUT_SKIP:        word = {18'd0, s.out_line_skip};
                    REG_SOURCE_BASE:     word = s.source_base_address;
                    REG_SOURCE_SKIP:     word = {18'd0, s.source_line_skip};
                    REG_PIXELS_PER_LINE: word = {18'd0, s.pixels_per_line};
                    REG_LINE_COUNT:      word = {16'd0, s.line_count};
                    default:             word = s.fill_color;
                endcase
                // upper bits of narrow registers get random junk to prove they are masked
                if (i == REG_OUT_SKIP || i == REG_SOURCE_SKIP || i == REG_PIXELS_PER_LINE)
                    word[31:14] = 18'($urandom());
                else if (i == REG_LINE_COUNT)
                    word[31:16] = 16'($urandom());
                else if (i == REG_TRANSFER_MODE)
                    word[31:1] = 31'($urandom());
                cfg_we    <= 1'b1;
                cfg_index <= cfg_index_t'(i);
                cfg_data  <= word;
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        setups_loaded++;
        @(negedge clk);
    endtask

    initial
    begin
        cfg_t setup;
        int   directed_items;
        int   pixels;
        int   cut_at;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // idle engine: step, unused kind, clear, then an empty start on reset registers and a clear
        push_item(KIND_STEP, '1);
        push_item(KIND_UNUSED, '0);
        push_item(KIND_CLEAR, pick_word());
        push_item(KIND_START, pick_word());
        push_item(KIND_CLEAR, pick_word());

        // fill 2x2 with maximum skips so both addresses wrap
        settle();
        setup                     = '0;
        setup.transfer_mode       = MODE_FILL;
        setup.out_base_address    = 32'hFFFF_FFF8;
        setup.out_line_skip       = '1;
        setup.source_base_address = 32'hFFFF_FFFC;
        setup.source_line_skip    = '1;
        setup.pixels_per_line     = 14'd2;
        setup.line_count          = 16'd2;
        setup.fill_color          = '1;
        apply_setup(setup, ALL_REGS);
        push_item(KIND_START, pick_word());
        push_item(KIND_START, pick_word());    // ignored while busy
        push_item(KIND_STEP, pick_word());
        push_item(KIND_CLEAR, pick_word());    // busy unaffected
        push_item(KIND_STEP, pick_word());
        push_item(KIND_STEP, pick_word());
        push_item(KIND_STEP, pick_word());
        push_item(KIND_STEP, pick_word());     // idle again

        // copy with the largest rectangle, then shrink it mid-transfer
        settle();
        setup                     = '0;
        setup.transfer_mode       = MODE_COPY;
        setup.pixels_per_line     = '1;
        setup.line_count          = '1;
        apply_setup(setup, ALL_REGS);
        push_item(KIND_START, pick_word());
        push_item(KIND_STEP, '0);
        push_item(KIND_STEP, '1);
        push_item(KIND_STEP, $urandom());
        settle();
        setup.pixels_per_line = 14'd1;
        setup.line_count      = 16'd1;
        apply_setup(setup, SIZE_REGS);
        push_item(KIND_STEP, $urandom());

        // zero line count with a nonzero width is still empty
        settle();
        setup.pixels_per_line = 14'd5;
        setup.line_count      = '0;
        apply_setup(setup, SIZE_REGS);
        push_item(KIND_START, pick_word());
        push_item(KIND_CLEAR, pick_word());

        directed_items = items_sent;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            settle();
            quiet = ($urandom_range(0, 4) == 0);

            setup.transfer_mode = mode_t'($urandom_range(0, 1));
            setup.out_base_address = ($urandom_range(0, 3) == 0) ?
                                     ~32'($urandom_range(0, 40)) : $urandom();
            setup.source_base_address = ($urandom_range(0, 3) == 0) ?
                                        ~32'($urandom_range(0, 40)) : $urandom();
            setup.out_line_skip = ($urandom_range(0, 3) == 0) ?
                                  14'($urandom_range(0, 16383)) : 14'($urandom_range(0, 3));
            setup.source_line_skip = ($urandom_range(0, 3) == 0) ?
                                     14'($urandom_range(0, 16383)) : 14'($urandom_range(0, 3));
            setup.fill_color = pick_word();
            case ($urandom_range(0, 19))
                0:
                begin
                    setup.pixels_per_line = 14'($urandom_range(1, 16383));
                    setup.line_count      = 16'($urandom_range(1, 65535));
                end
                1:
                begin
                    setup.pixels_per_line = $urandom_range(0, 1) ?
                                            '0 : 14'($urandom_range(0, 16383));
                    setup.line_count      = (setup.pixels_per_line != '0) ?
                                            '0 : 16'($urandom_range(0, 65535));
                end
                default:
                begin
                    setup.pixels_per_line = 14'($urandom_range(1, 6));
                    setup.line_count      = 16'($urandom_range(1, 4));
                end
            endcase
            apply_setup(setup, ALL_REGS);

            pixels = int'(setup.pixels_per_line) * int'(setup.line_count);
            if (pixels > 48)
                cut_at = $urandom_range(1, 12);
            else if (pixels > 1 && $urandom_range(0, 7) == 0)
                cut_at = $urandom_range(1, pixels - 1);
            else
                cut_at = 0;

            push_item(KIND_START, pick_word());
            for (int s = 0; s < ((cut_at > 0) ? cut_at : pixels); s++) begin
                // occasional stray transaction of any kind inside the stream
                if ($urandom_range(0, 9) == 0)
                    push_item(2'($urandom_range(0, 3)), pick_word());
                push_item(KIND_STEP, pick_word());
            end
            if (cut_at > 0) begin
                settle();
                setup.pixels_per_line = 14'($urandom_range(0, 3));
                setup.line_count      = 16'($urandom_range(0, 2));
                apply_setup(setup, SIZE_REGS);
                repeat ($urandom_range(1, 4)) push_item(KIND_STEP, pick_word());
            end
            if ($urandom_range(0, 2) == 0)
                push_item(KIND_CLEAR, pick_word());
        end

        quiet = 1'b0;
        settle();
        $display("run covered %0d input transactions under %0d register setups",
                 items_sent, setups_loaded);
        $display("with %0d pixel writes and %0d finished rectangles",
                 pixel_writes, rectangles_done);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
